>>> src/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants for the stream find-and-replace core
// Item formats, the command passed from the front end to the back end, and
// the register map of the configuration port.
// ----------------------------------------------------------------------------
package sfr_pkg;

  // Bytes carried by one command; also the longest replacement.
  localparam int CMD_BYTES = 8;
  localparam int CMD_IDX_W = $clog2(CMD_BYTES);
  // Width of byte counts and length registers.
  localparam int CNT_W     = 4;
  // Longest replacement, in bytes.
  localparam logic [CNT_W-1:0] REPL_MAX = CNT_W'(CMD_BYTES);

  // Command queue between front end and back end.
  localparam int CQ_DEPTH  = 4;
  localparam int CQ_PTR_W  = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W  = $clog2(CQ_DEPTH + 1);

  // Configuration port.
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;

  typedef enum logic [1:0] {
    REG_SEARCH_PATTERN = 2'd0,
    REG_SEARCH_LENGTH  = 2'd1,
    REG_REPLACEMENT    = 2'd2,
    REG_REPLACE_LENGTH = 2'd3
  } cfg_reg_t;

  // One input item.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
  } result_t;

  // A run of output bytes decided by the front end. A zero count with the
  // last flag set stands for the empty end marker.
  typedef struct packed {
    logic [8*CMD_BYTES-1:0] data;
    logic [CNT_W-1:0]       count;
    logic                   last;
  } sfr_cmd_t;

endpackage

>>> src/stream_find_and_replace_core.sv
// ----------------------------------------------------------------------------
// stream_find_and_replace_core: streaming byte find-and-replace
// Path: an item's command is written into the command queue, and its bytes
// then pass one by one through the result register of the back end.
// Throughput: one item per cycle while each item causes at most one result
// and results are popped; the back end sends one result byte per cycle while
// popped, so a multi-byte replacement or flush fills the 4-entry command queue.
// Reset: registers to defaults (search_length 1), window and queues empty.
// ----------------------------------------------------------------------------
module stream_find_and_replace_core import sfr_pkg::*; #(
  parameter int MAX_PATTERN_BYTES = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input items
  input  logic                  push,
  output logic                  full,
  input  in_item_t              item,
  // Result items
  output logic                  empty,
  input  logic                  pop,
  output result_t               result,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [8*CMD_BYTES-1:0] search_pattern;
  logic [CNT_W-1:0]       search_length;
  logic [8*CMD_BYTES-1:0] replacement;
  logic [CNT_W-1:0]       replace_length;

  cfg_reg_t reg_sel;
  logic     cfg_write;
  logic     accept;
  logic     cmd_push;
  sfr_cmd_t cmd;
  logic     cq_full;
  logic     cq_empty;
  logic     cq_pop;
  sfr_cmd_t cq_head;

  assign pready    = 1'b1;
  assign reg_sel   = cfg_reg_t'(paddr[CFG_ADDR_W-1:3]);
  assign cfg_write = psel && penable && pwrite && pready;
  assign full      = cq_full;
  assign accept    = push && !cq_full;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      search_pattern <= '0;
      search_length  <= CNT_W'(1);
      replacement    <= '0;
      replace_length <= '0;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_SEARCH_PATTERN: search_pattern <= pwdata;
        REG_SEARCH_LENGTH:  search_length  <= pwdata[CNT_W-1:0];
        REG_REPLACEMENT:    replacement    <= pwdata;
        REG_REPLACE_LENGTH: replace_length <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_sel)
      REG_SEARCH_PATTERN: prdata = search_pattern;
      REG_SEARCH_LENGTH:  prdata = CFG_DATA_W'(search_length);
      REG_REPLACEMENT:    prdata = replacement;
      REG_REPLACE_LENGTH: prdata = CFG_DATA_W'(replace_length);
      default:            prdata = '0;
    endcase
  end

  // Front end: window and classification.
  sfr_front #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .clear          (cfg_write && (reg_sel == REG_SEARCH_LENGTH)),
    .accept         (accept),
    .item           (item),
    .search_pattern (search_pattern),
    .search_length  (search_length),
    .replacement    (replacement),
    .replace_length (replace_length),
    .cmd_push       (cmd_push),
    .cmd            (cmd)
  );

  // Command queue between the two halves.
  sfr_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .push_cmd (cmd),
    .pop      (cq_pop),
    .full     (cq_full),
    .empty    (cq_empty),
    .head     (cq_head)
  );

  // Back end: byte output.
  sfr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cq_empty (cq_empty),
    .cq_head  (cq_head),
    .cq_pop   (cq_pop),
    .pop      (pop),
    .empty    (empty),
    .result   (result)
  );

endmodule

>>> src/sfr_front.sv
// ----------------------------------------------------------------------------
// sfr_front: window and match classification
// Holds the unresolved bytes, compares the window against the pattern as
// each item arrives, and turns each item that resolves bytes into one command.
// ----------------------------------------------------------------------------
module sfr_front import sfr_pkg::*; #(
  parameter int MAX_PATTERN_BYTES = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   clear,
  input  logic                   accept,
  input  in_item_t               item,
  input  logic [8*CMD_BYTES-1:0] search_pattern,
  input  logic [CNT_W-1:0]       search_length,
  input  logic [8*CMD_BYTES-1:0] replacement,
  input  logic [CNT_W-1:0]       replace_length,
  output logic                   cmd_push,
  output sfr_cmd_t               cmd
);

  localparam int FILL_W = $clog2(MAX_PATTERN_BYTES + 1);
  localparam logic [CNT_W-1:0] MAX_LEN = CNT_W'(MAX_PATTERN_BYTES);

  logic [7:0]        window [MAX_PATTERN_BYTES];
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;

  logic [CNT_W-1:0]  slen;
  logic [CNT_W-1:0]  rlen;
  logic [CNT_W-1:0]  fill_ext;
  logic              is_full;
  logic              match;
  logic [7:0]        merged [CMD_BYTES];
  logic [CMD_BYTES-1:0] lane_ok;
  logic [CNT_W-1:0]  count;

  // Effective lengths after clamping.
  always_comb begin
    if (search_length == '0) begin
      slen = CNT_W'(1);
    end else if (search_length > MAX_LEN) begin
      slen = MAX_LEN;
    end else begin
      slen = search_length;
    end
    rlen = (replace_length > REPL_MAX) ? REPL_MAX : replace_length;
  end

  assign fill_ext = CNT_W'(fill);
  assign is_full  = (fill_ext + CNT_W'(1)) == slen;

  // Window with the new byte dropped in at the fill position, compared
  // lane by lane against the pattern.
  for (genvar g = 0; g < CMD_BYTES; g++) begin : g_lane
    if (g < MAX_PATTERN_BYTES) begin : g_used
      assign merged[g]  = (fill_ext == CNT_W'(g)) ? item.in_byte : window[g];
      assign lane_ok[g] = (CNT_W'(g) >= slen) ||
                          (merged[g] == search_pattern[8*g +: 8]);
    end else begin : g_unused
      assign merged[g]  = 8'h00;
      assign lane_ok[g] = 1'b1;
    end
  end

  assign match = is_full && (&lane_ok);

  // Window storage: shift out the oldest byte when full, else keep the merge.
  for (genvar g = 0; g < MAX_PATTERN_BYTES; g++) begin : g_win
    always_ff @(posedge clk) begin
      if (accept) begin
        if (is_full && (g < MAX_PATTERN_BYTES - 1)) begin
          window[g] <= merged[(g < MAX_PATTERN_BYTES - 1) ? g + 1 : g];
        end else begin
          window[g] <= merged[g];
        end
      end
    end
  end

  // Fill count.
  always_comb begin
    fill_next = fill;
    if (clear) begin
      fill_next = '0;
    end else if (accept) begin
      if (item.in_last || match) begin
        fill_next = '0;
      end else if (!is_full) begin
        fill_next = FILL_W'(fill_ext + CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

  // Command: the replacement on a match, otherwise a run of window bytes.
  always_comb begin
    if (match) begin
      count = rlen;
    end else if (is_full) begin
      count = item.in_last ? slen : CNT_W'(1);
    end else begin
      count = item.in_last ? (fill_ext + CNT_W'(1)) : '0;
    end
  end

  always_comb begin
    cmd.count = count;
    cmd.last  = item.in_last;
    for (int i = 0; i < CMD_BYTES; i++) begin
      cmd.data[8*i +: 8] = match ? replacement[8*i +: 8] : merged[i];
    end
  end

  assign cmd_push = accept && ((count != '0) || item.in_last);

  // Between items the window never holds a full pattern.
  a_fill_below_len: assert property (@(posedge clk) disable iff (rst)
    fill_ext < slen)
    else $error("window fill reached the search length");

  // A command with nothing to send is only issued as the end marker.
  a_empty_cmd_is_last: assert property (@(posedge clk) disable iff (rst)
    (cmd_push && (cmd.count == '0)) |-> cmd.last)
    else $error("empty command issued without last");

endmodule

>>> src/sfr_cmd_fifo.sv
// ----------------------------------------------------------------------------
// sfr_cmd_fifo: command queue
// A short queue that decouples classification from byte output.
// ----------------------------------------------------------------------------
module sfr_cmd_fifo import sfr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  sfr_cmd_t push_cmd,
  input  logic     pop,
  output logic     full,
  output logic     empty,
  output sfr_cmd_t head
);

  sfr_cmd_t              entries [CQ_DEPTH];
  logic [CQ_PTR_W-1:0]   wr_ptr;
  logic [CQ_PTR_W-1:0]   rd_ptr;
  logic [CQ_CNT_W-1:0]   count;
  logic [CQ_CNT_W-1:0]   count_next;

  assign full  = count == CQ_CNT_W'(CQ_DEPTH);
  assign empty = count == '0;
  assign head  = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Occupancy tracking.
  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + CQ_CNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - CQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + CQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + CQ_PTR_W'(1);
      end
      count <= count_next;
    end
  end

  // The queue neither overflows nor underflows.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (push && full && !pop) == 1'b0 && (pop && empty) == 1'b0)
    else $error("command queue overrun or underrun");

endmodule

>>> src/sfr_back.sv
// ----------------------------------------------------------------------------
// sfr_back: byte output sequencer
// Walks queued commands one byte per cycle into a result register, bar stalls.
// ----------------------------------------------------------------------------
module sfr_back import sfr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     cq_empty,
  input  sfr_cmd_t cq_head,
  output logic     cq_pop,
  input  logic     pop,
  output logic     empty,
  output result_t  result
);

  logic [CMD_IDX_W-1:0] idx;
  logic                 out_full;
  result_t              out_q;
  logic                 advance;
  logic                 take;
  logic                 done;
  logic                 is_marker;

  // The result register moves on when empty or when its item is taken.
  assign advance   = !out_full || pop;
  assign take      = advance && !cq_empty;
  assign is_marker = cq_head.count == '0;
  assign done      = is_marker || ({1'b0, idx} == (cq_head.count - CNT_W'(1)));
  assign cq_pop    = take && done;

  assign empty  = !out_full;
  assign result = out_q;

  // Byte index within the current command.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      out_full <= 1'b0;
    end else begin
      if (take) begin
        idx <= done ? '0 : idx + CMD_IDX_W'(1);
      end
      if (advance) begin
        out_full <= !cq_empty;
      end
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (take) begin
      out_q.out_byte  <= is_marker ? 8'h00 : cq_head.data[8*idx +: 8];
      out_q.out_valid <= !is_marker;
      out_q.out_last  <= cq_head.last && done;
    end
  end

  // An end marker always closes its string.
  a_marker_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_full && !out_q.out_valid) |-> out_q.out_last)
    else $error("end marker without last");

endmodule
